### rtl/core/nps_pkg.sv
// Shared types, constants and tables of the note to PWM settings block.
package nps_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_TEMPO  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BEAT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME = 2'd2;
  localparam int CFG_DATA_W = 9;

  // Register reset values
  localparam logic [8:0] TEMPO_RESET  = 9'd120;
  localparam logic [4:0] BEAT_RESET   = 5'd4;
  localparam logic [6:0] VOLUME_RESET = 7'd5;
  localparam logic [6:0] VOLUME_MAX   = 7'd100;

  // Input codes
  localparam logic [2:0] LET_A      = 3'd0;
  localparam logic [2:0] LET_B      = 3'd1;
  localparam logic [2:0] LET_C      = 3'd2;
  localparam logic [2:0] LET_D      = 3'd3;
  localparam logic [2:0] LET_E      = 3'd4;
  localparam logic [2:0] LET_F      = 3'd5;
  localparam logic [2:0] LET_G      = 3'd6;
  localparam logic [2:0] LETTER_BAD = 3'd7;
  localparam logic [1:0] ACC_NAT    = 2'd0;
  localparam logic [1:0] ACC_SHARP  = 2'd1;
  localparam logic [1:0] ACC_FLAT   = 2'd2;
  localparam logic [1:0] ACC_BAD    = 2'd3;

  // Octaves 0 .. OCTAVES-1 are playable
  localparam int OCTAVES = 7;
  localparam logic [3:0] OCT_LIMIT = 4'(OCTAVES);

  // Timing arithmetic
  localparam int NUM_W      = 35;                 // beat * 60e6 * (2^(d+1)-1)
  localparam int DVS_W      = 9;                  // tempo
  localparam int DIV_STEP   = 5;                  // quotient bits per divider stage
  localparam int DIV_STAGES = NUM_W / DIV_STEP;
  localparam logic [NUM_W-1:0] US_PER_MIN = 35'd60000000;
  // floor(x/100) = (x * M100) >> 38, exact for x < 2^32
  localparam logic [31:0] M100 = 32'd2748779070;
  // floor(x/5) = (x * M5) >> 32, exact for x < 2^30
  localparam logic [29:0] M5 = 30'd858993460;
  localparam logic [31:0] SOUND_MAX = 32'h7FFF_FFFF;
  localparam logic [27:0] GAP_MAX   = 28'h7FF_FFFF;

  typedef struct packed {
    logic       is_pause;
    logic [2:0] letter;
    logic [2:0] octave;
    logic [1:0] accidental;
    logic [2:0] duration_code;
    logic [1:0] dots;
  } note_in_t;

  typedef struct packed {
    logic        tone_enable;
    logic [25:0] period_ns;
    logic [24:0] duty_ns;
    logic [30:0] sound_us;
    logic [26:0] gap_us;
    logic        bad_note;
  } note_out_t;

  // Note results that ride alongside the divider
  typedef struct packed {
    logic        tone_enable;
    logic [25:0] period_ns;
    logic [24:0] duty_ns;
    logic        bad_note;
    logic [3:0]  len_shift;
  } side_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DVS_W-1:0] dvs;
    side_t            side;
  } div_in_t;

  typedef struct packed {
    logic [NUM_W-1:0] quo;
    side_t            side;
  } div_out_t;

  // Tone period in ns of the lowest octave, semitone 0 = A
  function automatic logic [26:0] period_rom(input logic [3:0] semi);
    logic [26:0] p;
    case (semi)
      4'd0:    p = 27'd72727272;
      4'd1:    p = 27'd68645404;
      4'd2:    p = 27'd64792634;
      4'd3:    p = 27'd61156102;
      4'd4:    p = 27'd57723674;
      4'd5:    p = 27'd54483893;
      4'd6:    p = 27'd51425947;
      4'd7:    p = 27'd48539631;
      4'd8:    p = 27'd45815310;
      4'd9:    p = 27'd43243895;
      4'd10:   p = 27'd40816801;
      4'd11:   p = 27'd38525930;
      default: p = '0;
    endcase
    return p;
  endfunction

  // Semitone of each letter, counted from the A of the same octave, plus 12
  function automatic logic [3:0] letter_base(input logic [2:0] letter);
    logic [3:0] b;
    case (letter)
      LET_A:   b = 4'd12;
      LET_B:   b = 4'd14;
      LET_C:   b = 4'd3;
      LET_D:   b = 4'd5;
      LET_E:   b = 4'd7;
      LET_F:   b = 4'd8;
      LET_G:   b = 4'd10;
      default: b = 4'd0;
    endcase
    return b;
  endfunction

endpackage

### rtl/core/nps_front.sv
// Front stages: note decode, period lookup, duty and timing numerator.
module nps_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  nps_pkg::note_in_t in_word,
  input  logic [8:0]       tempo_bpm,
  input  logic [4:0]       beat_unit,
  input  logic [6:0]       volume,
  output logic             out_valid,
  input  logic             out_ready,
  output nps_pkg::div_in_t out_word
);

  // stage 1 registers
  logic        v1;
  logic        tone1;
  logic        bad1;
  logic [26:0] per1;
  logic [5:0]  half1;
  logic [8:0]  bf1;
  logic [3:0]  sh1;
  logic [8:0]  dvs1;
  // stage 2 registers
  logic        v2;
  logic        tone2;
  logic        bad2;
  logic [26:0] per2;
  logic [31:0] prod2;
  logic [nps_pkg::NUM_W-1:0] num2;
  logic [3:0]  sh2;
  logic [8:0]  dvs2;
  // stage 3 is the output register
  logic        v3;

  logic adv1, adv2, adv3;

  // decode combinational
  logic [3:0]  base;
  logic [3:0]  semi;
  logic [3:0]  row;
  logic [3:0]  oct_shift;
  logic [26:0] per;
  logic        bad;
  logic        tone;
  logic [6:0]  vol_sat;
  logic [4:0]  dot_mul;
  logic [8:0]  dvs;
  logic [63:0] duty_mul;

  // per-stage flow control: a stage moves when empty or when its consumer moves
  assign adv3     = !v3 || out_ready;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;
  assign out_valid = v3;

  // semitone, octave shift and validity of the note
  always_comb begin
    base = nps_pkg::letter_base(in_word.letter);
    case (in_word.accidental)
      nps_pkg::ACC_SHARP: semi = base + 4'd1;
      nps_pkg::ACC_FLAT:  semi = base - 4'd1;
      default:            semi = base;
    endcase
    if (semi >= 4'd12) begin
      row       = semi - 4'd12;
      oct_shift = {1'b0, in_word.octave} + 4'd1;
    end else begin
      row       = semi;
      oct_shift = {1'b0, in_word.octave};
    end
    per  = nps_pkg::period_rom(row) >> oct_shift;
    bad  = !in_word.is_pause &&
           (in_word.letter == nps_pkg::LETTER_BAD ||
            {1'b0, in_word.octave} >= nps_pkg::OCT_LIMIT ||
            in_word.accidental == nps_pkg::ACC_BAD);
    tone = !in_word.is_pause && !bad;
    vol_sat = (volume > nps_pkg::VOLUME_MAX) ? nps_pkg::VOLUME_MAX : volume;
    dot_mul = (5'd2 << in_word.dots) - 5'd1;
    dvs     = (tempo_bpm == 9'd0) ? 9'd1 : tempo_bpm;
  end

  // stage 1: decoded note and timing operands
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv1) begin
      v1 <= in_valid;
    end
    if (adv1) begin
      tone1 <= tone;
      bad1  <= bad;
      per1  <= tone ? per : '0;
      half1 <= vol_sat[6:1];
      bf1   <= 9'(beat_unit) * 9'(dot_mul[3:0]);
      sh1   <= 4'(in_word.duration_code) + 4'(in_word.dots);
      dvs1  <= dvs;
    end
  end

  // stage 2: period times duty percent, numerator of the note time
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv2) begin
      v2 <= v1;
    end
    if (adv2) begin
      tone2 <= tone1;
      bad2  <= bad1;
      per2  <= per1;
      prod2 <= 32'(33'(per1) * 33'(half1));
      num2  <= nps_pkg::NUM_W'(bf1) * nps_pkg::US_PER_MIN;
      sh2   <= sh1;
      dvs2  <= dvs1;
    end
  end

  // stage 3: divide by 100 through the reciprocal
  assign duty_mul = 64'(prod2) * 64'(nps_pkg::M100);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv3) begin
      v3 <= v2;
    end
    if (adv3) begin
      out_word.num              <= num2;
      out_word.dvs              <= dvs2;
      out_word.side.tone_enable <= tone2;
      out_word.side.period_ns   <= per2[25:0];
      out_word.side.duty_ns     <= duty_mul[62:38];
      out_word.side.bad_note    <= bad2;
      out_word.side.len_shift   <= sh2;
    end
  end

endmodule

### rtl/core/nps_div.sv
// Pipelined restoring divider of the note time numerator by the tempo.
module nps_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  nps_pkg::div_in_t  in_word,
  output logic              out_valid,
  input  logic              out_ready,
  output nps_pkg::div_out_t out_word
);

  localparam int NW = nps_pkg::NUM_W;
  localparam int DW = nps_pkg::DVS_W;
  localparam int NS = nps_pkg::DIV_STAGES;

  typedef struct packed {
    logic [NW-1:0] acc;
    logic [DW-1:0] rem;
  } step_t;

  // DIV_STEP quotient bits: numerator shifts out at the top, quotient in at the bottom
  function automatic step_t div_steps(input logic [NW-1:0] a_in,
                                      input logic [DW-1:0] r_in,
                                      input logic [DW-1:0] d);
    step_t     s;
    logic [DW:0] r2;
    s.acc = a_in;
    s.rem = r_in;
    for (int k = 0; k < nps_pkg::DIV_STEP; k++) begin
      r2    = {s.rem, s.acc[NW-1]};
      s.acc = {s.acc[NW-2:0], 1'b0};
      if (r2 >= {1'b0, d}) begin
        s.rem    = DW'(r2 - {1'b0, d});
        s.acc[0] = 1'b1;
      end else begin
        s.rem = r2[DW-1:0];
      end
    end
    return s;
  endfunction

  logic [NS-1:0]  v;
  logic [NS:0]    rdy;
  logic [NW-1:0]  acc  [NS];
  logic [DW-1:0]  rem  [NS];
  logic [DW-1:0]  dvs  [NS];
  nps_pkg::side_t side [NS];

  assign rdy[NS]   = out_ready;
  assign in_ready  = rdy[0];
  assign out_valid = v[NS-1];
  assign out_word.quo  = acc[NS-1];
  assign out_word.side = side[NS-1];

  for (genvar i = 0; i < NS; i++) begin : g_stage
    logic           up_valid;
    logic [NW-1:0]  up_acc;
    logic [DW-1:0]  up_rem;
    logic [DW-1:0]  up_dvs;
    nps_pkg::side_t up_side;
    step_t          nxt;

    if (i == 0) begin : g_first
      assign up_valid = in_valid;
      assign up_acc   = in_word.num;
      assign up_rem   = '0;
      assign up_dvs   = in_word.dvs;
      assign up_side  = in_word.side;
    end else begin : g_next
      assign up_valid = v[i-1];
      assign up_acc   = acc[i-1];
      assign up_rem   = rem[i-1];
      assign up_dvs   = dvs[i-1];
      assign up_side  = side[i-1];
    end

    assign rdy[i] = !v[i] || rdy[i+1];
    assign nxt    = div_steps(up_acc, up_rem, up_dvs);

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (rdy[i]) begin
        v[i] <= up_valid;
      end
      if (rdy[i]) begin
        acc[i]  <= nxt.acc;
        rem[i]  <= nxt.rem;
        dvs[i]  <= up_dvs;
        side[i] <= up_side;
      end
    end
  end

endmodule

### rtl/core/nps_back.sv
// Back stages: note length scaling, 95/5 split and saturation of the times.
module nps_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  nps_pkg::div_out_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output nps_pkg::note_out_t out_word
);

  // stage 1 registers
  logic           v1;
  logic [31:0]    t1;
  logic [27:0]    g1;
  logic           hi1;
  nps_pkg::side_t side1;
  // stage 2 is the output register
  logic           v2;

  logic adv1, adv2;

  logic [nps_pkg::NUM_W-1:0] t_full;
  logic [59:0]    g_mul;
  logic [31:0]    g20;
  logic           part;
  logic [31:0]    s_raw;
  logic           s_sat;
  logic           g_sat;

  assign adv2      = !v2 || out_ready;
  assign adv1      = !v1 || adv2;
  assign in_ready  = adv1;
  assign out_valid = v2;

  // note time: quotient over the power of two of note length and dot count
  assign t_full = in_word.quo >> in_word.side.len_shift;
  // T/20 = (T/4)/5
  assign g_mul  = 60'(t_full[31:2]) * 60'(nps_pkg::M5);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv1) begin
      v1 <= in_valid;
    end
    if (adv1) begin
      t1    <= t_full[31:0];
      g1    <= g_mul[59:32];
      hi1   <= |t_full[nps_pkg::NUM_W-1:32];
      side1 <= in_word.side;
    end
  end

  // sound = T - ceil(T/20); huge times saturate both fields
  always_comb begin
    g20   = {g1[27:0], 4'b0} + {2'b0, g1[27:0], 2'b0};
    part  = (t1 != g20);
    s_raw = t1 - 32'(g1) - 32'(part);
    s_sat = hi1 || (s_raw > nps_pkg::SOUND_MAX);
    g_sat = hi1 || (g1 > nps_pkg::GAP_MAX);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv2) begin
      v2 <= v1;
    end
    if (adv2) begin
      out_word.tone_enable <= side1.tone_enable;
      out_word.period_ns   <= side1.period_ns;
      out_word.duty_ns     <= side1.duty_ns;
      out_word.bad_note    <= side1.bad_note;
      if (side1.bad_note) begin
        out_word.sound_us <= '0;
        out_word.gap_us   <= '0;
      end else begin
        out_word.sound_us <= s_sat ? nps_pkg::SOUND_MAX[30:0] : s_raw[30:0];
        out_word.gap_us   <= g_sat ? nps_pkg::GAP_MAX[26:0] : g1[26:0];
      end
    end
  end

endmodule

### rtl/core/note_to_pwm_settings.sv
// An accepted note word passes the front stages, the tempo divider and the back stages.
// Throughput: one word per cycle while out_ready holds; the 7-stage tempo divider makes up most of the depth.
// Each stage holds under backpressure and refills from upstream as it drains.
// Reset clears all stage valid bits and loads tempo 120, beat unit 4, volume 5.
// Top level of the note to PWM settings block.
module note_to_pwm_settings (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  nps_pkg::note_in_t    in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output nps_pkg::note_out_t   out_word,
  input  logic                 cfg_write,
  input  logic [nps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nps_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [8:0] tempo_bpm;
  logic [4:0] beat_unit;
  logic [6:0] volume;

  logic              f_valid, f_ready;
  nps_pkg::div_in_t  f_word;
  logic              d_valid, d_ready;
  nps_pkg::div_out_t d_word;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tempo_bpm <= nps_pkg::TEMPO_RESET;
      beat_unit <= nps_pkg::BEAT_RESET;
      volume    <= nps_pkg::VOLUME_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        nps_pkg::REG_TEMPO:  tempo_bpm <= cfg_data[8:0];
        nps_pkg::REG_BEAT:   beat_unit <= cfg_data[4:0];
        nps_pkg::REG_VOLUME: volume    <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  nps_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .tempo_bpm (tempo_bpm),
    .beat_unit (beat_unit),
    .volume    (volume),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_word  (f_word)
  );

  nps_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_word   (f_word),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .out_word  (d_word)
  );

  nps_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d_valid),
    .in_ready  (d_ready),
    .in_word   (d_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

`ifndef SYNTHESIS
  // an invalid note carries nothing but its flag
  a_bad_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.bad_note |->
      !out_word.tone_enable && out_word.period_ns == '0 && out_word.duty_ns == '0 &&
      out_word.sound_us == '0 && out_word.gap_us == '0)
    else $error("bad note word has nonzero fields");

  // a sounding note has a real period and no error
  a_tone_period: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.tone_enable |-> !out_word.bad_note && out_word.period_ns != '0)
    else $error("sounding note without period");

  // duty is at most half the period, and zero when silent
  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.duty_ns <= 25'(out_word.period_ns >> 1)) &&
                  (out_word.tone_enable || out_word.duty_ns == '0))
    else $error("duty out of range");

  // the sounding part never falls below the gap
  a_split_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> 32'(out_word.sound_us) >= 32'(out_word.gap_us))
    else $error("sound time below gap time");

  // nothing leaves right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");
`endif

endmodule

### tb/sv/note_to_pwm_settings_test.sv
// Self-checking testbench for the note to PWM settings block.
module note_to_pwm_settings_test;

  localparam int LATENCY     = 12;
  localparam int PHASES      = 8;
  localparam int PHASE_WORDS = 212;
  localparam int HOLD_CYCLES = 400;
  localparam int IN_W        = $bits(nps_pkg::note_in_t);

  localparam logic [2:0] OCT_BAD = 3'(nps_pkg::OCTAVES);

  // Lowest-octave tone periods in ns, A up to G sharp
  localparam int unsigned BASE_PERIOD_NS [12] = '{
    72727272, 68645404, 64792634, 61156102, 57723674, 54483893,
    51425947, 48539631, 45815310, 43243895, 40816801, 38525930
  };
  // Semitones of each letter relative to A of the same octave
  localparam int NOTE_SEMI [7] = '{0, 2, -9, -7, -5, -4, -2};

  // Register values per phase; phase 0 runs on reset values, 5 and 6 are random
  localparam int PH_TEMPO  [PHASES] = '{120, 1, 400, 0, 511, 0, 0, 2};
  localparam int PH_BEAT   [PHASES] = '{4, 1, 16, 31, 0, 0, 0, 8};
  localparam int PH_VOLUME [PHASES] = '{5, 0, 100, 127, 1, 0, 0, 64};

  // Results that can be read straight off the spec at reset settings
  localparam nps_pkg::note_out_t A4_QUARTER =
    '{1'b1, 26'd2272727, 25'd45454, 31'd475000, 27'd25000, 1'b0};
  localparam nps_pkg::note_out_t PAUSE_QUARTER =
    '{1'b0, 26'd0, 25'd0, 31'd475000, 27'd25000, 1'b0};
  localparam nps_pkg::note_out_t PAUSE_WHOLE_3DOT =
    '{1'b0, 26'd0, 25'd0, 31'd3562500, 27'd187500, 1'b0};
  localparam nps_pkg::note_out_t BAD_RESULT =
    '{1'b0, 26'd0, 25'd0, 31'd0, 27'd0, 1'b1};

  typedef struct packed {
    nps_pkg::note_in_t  word;
    logic               typed;
    nps_pkg::note_out_t want;
  } stim_row_t;

  // Directed words: {pause, letter, octave, accidental, duration, dots}
  localparam int DIR_ROWS = 20;
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    '{'{1'b0, nps_pkg::LET_A, 3'd4, nps_pkg::ACC_NAT, 3'd2, 2'd0}, 1'b1, A4_QUARTER},
    '{'{1'b1, nps_pkg::LET_A, 3'd4, nps_pkg::ACC_NAT, 3'd2, 2'd0}, 1'b1, PAUSE_QUARTER},
    '{'{1'b1, nps_pkg::LET_C, 3'd0, nps_pkg::ACC_NAT, 3'd0, 2'd3}, 1'b1, PAUSE_WHOLE_3DOT},
    '{'{1'b1, nps_pkg::LETTER_BAD, OCT_BAD, nps_pkg::ACC_BAD, 3'd2, 2'd0}, 1'b1,
      PAUSE_QUARTER},
    '{'{1'b0, nps_pkg::LETTER_BAD, 3'd4, nps_pkg::ACC_NAT, 3'd2, 2'd0}, 1'b1, BAD_RESULT},
    '{'{1'b0, nps_pkg::LET_D, OCT_BAD, nps_pkg::ACC_NAT, 3'd1, 2'd1}, 1'b1, BAD_RESULT},
    '{'{1'b0, nps_pkg::LET_E, 3'd3, nps_pkg::ACC_BAD, 3'd4, 2'd2}, 1'b1, BAD_RESULT},
    '{'{1'b0, nps_pkg::LETTER_BAD, OCT_BAD, nps_pkg::ACC_BAD, 3'd7, 2'd3}, 1'b1,
      BAD_RESULT},
    '{'{1'b0, nps_pkg::LET_C, 3'd0, nps_pkg::ACC_FLAT, 3'd0, 2'd0}, 1'b0, '0},
    '{'{1'b0, nps_pkg::LET_C, 3'd0, nps_pkg::ACC_NAT, 3'd0, 2'd3}, 1'b0, '0},
    '{'{1'b0, nps_pkg::LET_B, 3'd6, nps_pkg::ACC_SHARP, 3'd4, 2'd0}, 1'b0, '0},
    '{'{1'b0, nps_pkg::LET_G, 3'd6, nps_pkg::ACC_SHARP, 3'd4, 2'd3}, 1'b0, '0},
    '{'{1'b0, nps_pkg::LET_E, 3'd3, nps_pkg::ACC_SHARP, 3'd2, 2'd1}, 1'b0, '0},
    '{'{1'b0, nps_pkg::LET_F, 3'd2, nps_pkg::ACC_FLAT, 3'd3, 2'd0}, 1'b0, '0},
    '{'{1'b0, nps_pkg::LET_D, 3'd5, nps_pkg::ACC_NAT, 3'd1, 2'd2}, 1'b0, '0},
    '{'{1'b0, nps_pkg::LET_G, 3'd0, nps_pkg::ACC_SHARP, 3'd2, 2'd2}, 1'b0, '0},
    '{'{1'b0, nps_pkg::LET_A, 3'd0, nps_pkg::ACC_FLAT, 3'd5, 2'd1}, 1'b0, '0},
    '{'{1'b0, nps_pkg::LET_B, 3'd1, nps_pkg::ACC_NAT, 3'd7, 2'd3}, 1'b0, '0},
    '{'{1'b1, nps_pkg::LET_G, 3'd6, nps_pkg::ACC_SHARP, 3'd7, 2'd3}, 1'b0, '0},
    '{'{1'b0, nps_pkg::LET_C, 3'd4, nps_pkg::ACC_SHARP, 3'd6, 2'd0}, 1'b0, '0}
  };

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  nps_pkg::note_in_t              in_word = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  nps_pkg::note_out_t             out_word;
  logic                           cfg_write = 1'b0;
  logic [nps_pkg::CFG_IDX_W-1:0]  cfg_index = nps_pkg::REG_TEMPO;
  logic [nps_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Register copies used for prediction
  logic [8:0] cur_tempo  = nps_pkg::TEMPO_RESET;
  logic [4:0] cur_beat   = nps_pkg::BEAT_RESET;
  logic [6:0] cur_volume = nps_pkg::VOLUME_RESET;

  nps_pkg::note_out_t pending_settings [$];
  nps_pkg::note_out_t seen_want;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  bit        hold_req = 1'b0;
  int        mismatch_count = 0;
  int        words_sent = 0;
  int        pause_words = 0;
  int        bad_words = 0;

  note_to_pwm_settings dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // PWM settings for one note word under the current register values
  function automatic nps_pkg::note_out_t calc_settings(input nps_pkg::note_in_t w);
    nps_pkg::note_out_t r;
    int                 semi;
    longint unsigned    per, vol, tempo_eff, num, den, t, snd, gp;
    r = '0;
    if (!w.is_pause) begin
      if (w.letter == nps_pkg::LETTER_BAD || w.octave >= nps_pkg::OCTAVES ||
          w.accidental == nps_pkg::ACC_BAD) begin
        r.bad_note = 1'b1;
        return r;
      end
      semi = 60 + NOTE_SEMI[w.letter] + 12 * (int'(w.octave) - 4);
      if (w.accidental == nps_pkg::ACC_SHARP)
        semi = semi + 1;
      else if (w.accidental == nps_pkg::ACC_FLAT)
        semi = semi - 1;
      if (semi < 0)
        semi = 0;
      per = BASE_PERIOD_NS[semi % 12] >> (semi / 12);
      vol = (cur_volume > nps_pkg::VOLUME_MAX) ? nps_pkg::VOLUME_MAX : cur_volume;
      r.tone_enable = 1'b1;
      r.period_ns   = 26'(per);
      r.duty_ns     = 25'(per * (vol / 2) / 100);
    end
    // Note time: beat * 1 min * dotted factor / (length * tempo)
    tempo_eff = (cur_tempo == 0) ? 1 : cur_tempo;
    num = cur_beat;
    num = num * 60000000 * ((64'd2 << w.dots) - 1);
    den = (64'd1 << w.duration_code) * (64'd1 << w.dots) * tempo_eff;
    t   = num / den;
    snd = t * 95 / 100;
    gp  = t * 5 / 100;
    r.sound_us = (snd > 64'h7FFF_FFFF) ? '1 : 31'(snd);
    r.gap_us   = (gp > 64'h7FF_FFFF) ? '1 : 27'(gp);
    return r;
  endfunction

  // Random note word: mostly playable notes, some pauses, junk and long codes
  function automatic nps_pkg::note_in_t random_note();
    nps_pkg::note_in_t w;
    int                kind;
    kind = $urandom_range(99);
    w.is_pause      = 1'b0;
    w.letter        = 3'($urandom_range(6));
    w.octave        = 3'($urandom_range(nps_pkg::OCTAVES - 1));
    w.accidental    = 2'($urandom_range(2));
    w.duration_code = 3'($urandom_range(4));
    w.dots          = 2'($urandom_range(3));
    if (kind < 12) begin
      w.is_pause   = 1'b1;
      w.letter     = 3'($urandom);
      w.octave     = 3'($urandom);
      w.accidental = 2'($urandom);
    end else if (kind < 24) begin
      w = nps_pkg::note_in_t'(IN_W'($urandom));
    end else if (kind < 28) begin
      w.duration_code = 3'($urandom_range(7, 5));
    end
    return w;
  endfunction

  // Offer one word after a random gap and hold it until accepted
  task automatic offer_note(input nps_pkg::note_in_t w, input logic typed,
                            input nps_pkg::note_out_t want);
    nps_pkg::note_out_t exp_word;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    exp_word = typed ? want : calc_settings(w);
    pending_settings.push_back(exp_word);
    words_sent++;
    if (w.is_pause)
      pause_words++;
    if (exp_word.bad_note)
      bad_words++;
  endtask

  // Stop offering and let the pipeline empty out
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_settings.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  // Write all three registers back to back, then track them
  task automatic set_config(input logic [8:0] tempo, input logic [4:0] beat,
                            input logic [6:0] vol);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= nps_pkg::REG_TEMPO;
    cfg_data  <= tempo;
    @(posedge clk);
    cfg_index <= nps_pkg::REG_BEAT;
    cfg_data  <= nps_pkg::CFG_DATA_W'(beat);
    @(posedge clk);
    cfg_index <= nps_pkg::REG_VOLUME;
    cfg_data  <= nps_pkg::CFG_DATA_W'(vol);
    @(posedge clk);
    cfg_write  <= 1'b0;
    cur_tempo  = tempo;
    cur_beat   = beat;
    cur_volume = vol;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // Output side: random stalls, plus one long hold when requested
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Compare each result word with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_settings.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result word, expected none actual %h", $time, out_word);
      end else begin
        seen_want = pending_settings.pop_front();
        check_field("tone_enable", 64'(seen_want.tone_enable), 64'(out_word.tone_enable));
        check_field("period_ns", 64'(seen_want.period_ns), 64'(out_word.period_ns));
        check_field("duty_ns", 64'(seen_want.duty_ns), 64'(out_word.duty_ns));
        check_field("sound_us", 64'(seen_want.sound_us), 64'(out_word.sound_us));
        check_field("gap_us", 64'(seen_want.gap_us), 64'(out_word.gap_us));
        check_field("bad_note", 64'(seen_want.bad_note), 64'(out_word.bad_note));
      end
    end
  end

  // Main sequence
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < PHASES; p++) begin
      if (p < 3) begin
        send_idle_pct = 33;
        recv_idle_pct = 45;
      end else if (p < 6) begin
        send_idle_pct = 45;
        recv_idle_pct = 33;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p == 0) begin
        for (int i = 0; i < DIR_ROWS; i++)
          offer_note(DIRECTED[i].word, DIRECTED[i].typed, DIRECTED[i].want);
      end else begin
        wait_idle();
        if (p == 5 || p == 6)
          set_config(9'($urandom_range(400, 1)), 5'(1 << $urandom_range(4)),
                     7'($urandom_range(100)));
        else
          set_config(9'(PH_TEMPO[p]), 5'(PH_BEAT[p]), 7'(PH_VOLUME[p]));
      end
      // Back up the pipeline once while the sender keeps pushing
      if (p == 6)
        hold_req = 1'b1;
      for (int i = 0; i < PHASE_WORDS; i++)
        offer_note(random_note(), 1'b0, '0);
    end
    wait_idle();
    $display("Checked %0d note words (%0d pauses, %0d bad codes) across %0d settings,",
             words_sent, pause_words, bad_words, PHASES);
    $display("with mixed send/receive stalls and a %0d-cycle output hold.", HOLD_CYCLES);
    if (mismatch_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Watchdog
  initial begin
    #800000;
    $display("Timed out with %0d results outstanding", pending_settings.size());
    $display("status: fail");
    $finish;
  end

endmodule

### filelist.f
rtl/core/nps_pkg.sv
rtl/core/nps_front.sv
rtl/core/nps_div.sv
rtl/core/nps_back.sv
rtl/core/note_to_pwm_settings.sv
tb/sv/note_to_pwm_settings_test.sv
